// ===== rtl/core/tlpq_pkg.sv =====
`timescale 1ns / 1ps

package tlpq_pkg;

	// Default number of entries in each queue
	localparam int QUEUE_DEPTH = 4;

	localparam int VALUE_W = 32;

	// Command codes carried on the input tuser
	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_ENQ_HIGH = 2'd0;
	localparam cmd_t CMD_ENQ_LOW  = 2'd1;
	localparam cmd_t CMD_DEQ      = 2'd2;

	// Result status codes
	typedef logic [1:0] res_t;
	localparam res_t RES_OK    = 2'd0;
	localparam res_t RES_FULL  = 2'd1;
	localparam res_t RES_EMPTY = 2'd2;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_LOAD
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;
		logic exec;
		logic rd_capture;
		logic load_out;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic need_read;
		logic out_free;
	} dp_stat_t;

endpackage

// ===== rtl/core/two_level_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// Two-queue strict priority queue of signed 32-bit values.
// Input stream: s_axis_tuser carries the command (enqueue high, enqueue low,
// dequeue), s_axis_tdata the value to enqueue. Output stream: one item per
// input item, m_axis_tdata the dequeued value (zero unless a dequeue
// succeeded), m_axis_tuser the status (ok, full, empty) and the queue flag.
// A dequeue serves the high queue whenever it holds anything. A queue
// reports full once its write position reaches DEPTH and frees its space
// only when it drains completely.
// Timing: an item is accepted, executed next cycle, and its result enters
// the output register from the load state, which waits while the output
// register is full; a successful dequeue first passes the read state for
// the registered RAM read. The controller handles one item at a time,
// stepping through its execute/read/load sequence.
// While the receiver stalls, the result waits in the output register; the
// next item is still accepted and executed, and its result waits until the
// output register is taken.
// Reset empties both queues at once; entry storage is not cleared.

module two_level_priority_queue_unit import tlpq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,  // [31:0] value_in
	input  logic [1:0]  s_axis_tuser,  // [1:0] command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] value_out
	output logic [2:0]  m_axis_tuser   // [1:0] status, [2] from_low_queue
);

	ctrl_cmd_t ctrl_cmd;
	dp_stat_t  dp_stat;
	res_t      out_status;
	logic      out_from_low;

	tlpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (dp_stat),
		.cmd      (ctrl_cmd)
	);

	tlpq_datapath #(.DEPTH(DEPTH)) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (ctrl_cmd),
		.stat         (dp_stat),
		.in_cmd       (s_axis_tuser),
		.in_value     (s_axis_tdata),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_status   (out_status),
		.out_value    (m_axis_tdata),
		.out_from_low (out_from_low)
	);

	assign m_axis_tuser = {out_from_low, out_status};

endmodule

// ===== rtl/core/tlpq_ram.sv =====
`timescale 1ns / 1ps

module tlpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/tlpq_ctrl.sv =====
`timescale 1ns / 1ps

module tlpq_ctrl import tlpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		in_ready       = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = stat.need_read ? S_READ : S_LOAD;
			end
			S_READ: begin
				cmd.rd_capture = 1'b1;
				state_d        = S_LOAD;
			end
			S_LOAD: begin
				// Hold the result until the output register frees up
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/tlpq_datapath.sv =====
`timescale 1ns / 1ps

module tlpq_datapath import tlpq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          cmd,
	output dp_stat_t           stat,
	input  cmd_t               in_cmd,
	input  logic [VALUE_W-1:0] in_value,
	output logic               out_valid,
	input  logic               out_ready,
	output res_t               out_status,
	output logic [VALUE_W-1:0] out_value,
	output logic               out_from_low
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int PW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] FULL_AT = PW'(DEPTH);
	localparam logic [PW-1:0] ONE     = PW'(1);

	cmd_t               cmd_q;
	logic [VALUE_W-1:0] val_q;
	logic [PW-1:0]      hi_head_q, hi_wr_q, lo_head_q, lo_wr_q;
	logic [PW-1:0]      hi_head_inc, lo_head_inc;
	logic               hi_full, lo_full, hi_busy, lo_busy;
	logic               we_hi, we_lo, re_hi, re_lo;
	logic [VALUE_W-1:0] rdata_hi, rdata_lo;
	res_t               res_status_q;
	logic [VALUE_W-1:0] res_value_q;
	logic               res_from_low_q;
	logic               out_valid_q;
	res_t               out_status_q;
	logic [VALUE_W-1:0] out_value_q;
	logic               out_from_low_q;

	assign hi_full     = (hi_wr_q == FULL_AT);
	assign lo_full     = (lo_wr_q == FULL_AT);
	assign hi_busy     = (hi_wr_q != '0);
	assign lo_busy     = (lo_wr_q != '0);
	assign hi_head_inc = hi_head_q + ONE;
	assign lo_head_inc = lo_head_q + ONE;

	// Memory strobes for the item at work
	assign we_hi = cmd.exec && (cmd_q == CMD_ENQ_HIGH) && !hi_full;
	assign we_lo = cmd.exec && (cmd_q == CMD_ENQ_LOW) && !lo_full;
	assign re_hi = cmd.exec && (cmd_q == CMD_DEQ) && hi_busy;
	assign re_lo = cmd.exec && (cmd_q == CMD_DEQ) && !hi_busy && lo_busy;

	assign stat.need_read = (cmd_q == CMD_DEQ) && (hi_busy || lo_busy);
	assign stat.out_free  = !out_valid_q || out_ready;

	tlpq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_hi (
		.clk   (clk),
		.we    (we_hi),
		.waddr (hi_wr_q[AW-1:0]),
		.wdata (val_q),
		.re    (re_hi),
		.raddr (hi_head_q[AW-1:0]),
		.rdata (rdata_hi)
	);

	tlpq_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_ram_lo (
		.clk   (clk),
		.we    (we_lo),
		.waddr (lo_wr_q[AW-1:0]),
		.wdata (val_q),
		.re    (re_lo),
		.raddr (lo_head_q[AW-1:0]),
		.rdata (rdata_lo)
	);

	// Capture the accepted item
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= in_cmd;
			val_q <= in_value;
		end
	end

	// Advance queue positions; a drained queue returns to the start
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_head_q <= '0;
			hi_wr_q   <= '0;
			lo_head_q <= '0;
			lo_wr_q   <= '0;
		end else begin
			if (we_hi) begin
				hi_wr_q <= hi_wr_q + ONE;
			end
			if (we_lo) begin
				lo_wr_q <= lo_wr_q + ONE;
			end
			if (re_hi) begin
				if (hi_head_inc >= hi_wr_q) begin
					hi_head_q <= '0;
					hi_wr_q   <= '0;
				end else begin
					hi_head_q <= hi_head_inc;
				end
			end
			if (re_lo) begin
				if (lo_head_inc >= lo_wr_q) begin
					lo_head_q <= '0;
					lo_wr_q   <= '0;
				end else begin
					lo_head_q <= lo_head_inc;
				end
			end
		end
	end

	// Build the result; the dequeued value is captured from the RAM in the read state
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q   <= RES_OK;
			res_value_q    <= '0;
			res_from_low_q <= 1'b0;
			case (cmd_q)
				CMD_ENQ_HIGH: begin
					if (hi_full) begin
						res_status_q <= RES_FULL;
					end
				end
				CMD_ENQ_LOW: begin
					if (lo_full) begin
						res_status_q <= RES_FULL;
					end
				end
				CMD_DEQ: begin
					if (!hi_busy && !lo_busy) begin
						res_status_q <= RES_EMPTY;
					end
					res_from_low_q <= !hi_busy && lo_busy;
				end
				default: begin
					res_status_q <= RES_OK;
				end
			endcase
		end
		if (cmd.rd_capture) begin
			res_value_q <= res_from_low_q ? rdata_lo : rdata_hi;
		end
	end

	// Output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_status_q   <= res_status_q;
			out_value_q    <= res_value_q;
			out_from_low_q <= res_from_low_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_status   = out_status_q;
	assign out_value    = out_value_q;
	assign out_from_low = out_from_low_q;

endmodule

// ===== tb/sv/tlpq_checker.sv =====
`timescale 1ns / 1ps

module tlpq_checker import tlpq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  logic [31:0] cmd_data,   // [31:0] value_in
	input  logic [1:0]  cmd_user,   // [1:0] command
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [31:0] res_data,   // [31:0] value_out
	input  logic [2:0]  res_user,   // [1:0] status, [2] from_low_queue
	output int          mismatches,
	output int          outstanding,
	output int          high_serves,
	output int          low_serves,
	output int          full_rejects,
	output int          empty_rejects,
	output int          unused_codes
);

	typedef struct packed {
		res_t        status;
		logic [31:0] value;
		logic        from_low;
	} queue_result_t;

	// Shadow copy of both queues
	logic [31:0] high_entries [QUEUE_DEPTH];
	logic [31:0] low_entries  [QUEUE_DEPTH];
	int unsigned high_head = 0;
	int unsigned high_fill = 0;
	int unsigned low_head  = 0;
	int unsigned low_fill  = 0;

	int error_count   = 0;
	int high_count    = 0;
	int low_count     = 0;
	int full_count    = 0;
	int empty_count   = 0;
	int unused_count  = 0;

	queue_result_t awaited_results [$];

	assign mismatches    = error_count;
	assign high_serves   = high_count;
	assign low_serves    = low_count;
	assign full_rejects  = full_count;
	assign empty_rejects = empty_count;
	assign unused_codes  = unused_count;

	initial outstanding = 0;

	// Apply one command to the shadow queues and return what the block must answer
	function automatic queue_result_t serve_command(cmd_t code, logic [31:0] value);
		queue_result_t r;
		r = '0;
		r.status = RES_OK;
		case (code)
			CMD_ENQ_HIGH: begin
				if (high_fill >= QUEUE_DEPTH) begin
					r.status = RES_FULL;
					full_count++;
				end else begin
					high_entries[high_fill] = value;
					high_fill++;
				end
			end
			CMD_ENQ_LOW: begin
				if (low_fill >= QUEUE_DEPTH) begin
					r.status = RES_FULL;
					full_count++;
				end else begin
					low_entries[low_fill] = value;
					low_fill++;
				end
			end
			CMD_DEQ: begin
				// High queue wins whenever it holds anything
				if (high_fill != 0) begin
					r.value = high_entries[high_head];
					high_head++;
					high_count++;
					// Reclaim the space only once fully drained
					if (high_head >= high_fill) begin
						high_head = 0;
						high_fill = 0;
					end
				end else if (low_fill != 0) begin
					r.value = low_entries[low_head];
					r.from_low = 1'b1;
					low_head++;
					low_count++;
					if (low_head >= low_fill) begin
						low_head = 0;
						low_fill = 0;
					end
				end else begin
					r.status = RES_EMPTY;
					empty_count++;
				end
			end
			default: begin
				unused_count++;
			end
		endcase
		return r;
	endfunction

	// Predict on every accepted command, compare every accepted result
	always @(posedge clk) begin : track_items
		queue_result_t want;
		bit bad;
		if (arst_n) begin
			if (cmd_valid && cmd_ready)
				awaited_results.push_back(serve_command(cmd_t'(cmd_user), cmd_data));
			if (res_valid && res_ready) begin
				if (awaited_results.size() == 0) begin
					$display("%0t: unexpected result: status %0d value %h from_low %0b",
						$time, res_user[1:0], res_data, res_user[2]);
					error_count++;
				end else begin
					want = awaited_results.pop_front();
					bad = 1'b0;
					if (res_user[1:0] !== want.status) begin
						$display("%0t: status mismatch: expected %0d, got %0d",
							$time, want.status, res_user[1:0]);
						bad = 1'b1;
					end
					if (res_data !== want.value) begin
						$display("%0t: value mismatch: expected %h, got %h",
							$time, want.value, res_data);
						bad = 1'b1;
					end
					if (res_user[2] !== want.from_low) begin
						$display("%0t: queue flag mismatch: expected %0b, got %0b",
							$time, want.from_low, res_user[2]);
						bad = 1'b1;
					end
					if (bad)
						error_count++;
				end
			end
			outstanding <= awaited_results.size();
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import tlpq_pkg::*;

	localparam cmd_t CMD_NOP       = 2'd3;
	localparam int   RANDOM_ITEMS  = 826;
	localparam int   RX_HOLD       = 120;
	localparam int   STALL_LIMIT   = 2000;
	localparam int   DRAIN_CYCLES  = 20;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] value_in
	logic [1:0]  s_axis_tuser;   // [1:0] command
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] value_out
	logic [2:0]  m_axis_tuser;   // [1:0] status, [2] from_low_queue

	int mismatches;
	int outstanding;
	int high_serves;
	int low_serves;
	int full_rejects;
	int empty_rejects;
	int unused_codes;

	bit tx_no_idle    = 1'b0;
	bit rx_no_idle    = 1'b0;
	int hold_requests = 0;
	int holds_served  = 0;
	int rx_wait;
	int stalled_cycles = 0;

	int sent;
	int seg;
	int seg_len;
	int cut_high;
	int cut_low;
	int pick;
	bit burst;
	cmd_t        cmd;
	logic [31:0] value;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	two_level_priority_queue_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	tlpq_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (s_axis_tvalid),
		.cmd_ready     (s_axis_tready),
		.cmd_data      (s_axis_tdata),
		.cmd_user      (s_axis_tuser),
		.res_valid     (m_axis_tvalid),
		.res_ready     (m_axis_tready),
		.res_data      (m_axis_tdata),
		.res_user      (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.high_serves   (high_serves),
		.low_serves    (low_serves),
		.full_rejects  (full_rejects),
		.empty_rejects (empty_rejects),
		.unused_codes  (unused_codes)
	);

	// Offer one item after a random gap and hold it until accepted
	task automatic send_item(input cmd_t code, input logic [31:0] data);
		int gap;
		gap = tx_no_idle ? 0 : $urandom_range(0, 16);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= code;
		s_axis_tdata  <= data;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	// Drop valid and wait until every outstanding result has been taken
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
	endtask

	// Result side: random stalls per item, plus a long hold-off on request
	initial begin
		m_axis_tready = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_requests != holds_served) begin
				holds_served++;
				rx_wait = RX_HOLD;
			end else begin
				rx_wait = rx_no_idle ? 0 : $urandom_range(0, 16);
			end
			if (rx_wait != 0) begin
				m_axis_tready <= 1'b0;
				repeat (rx_wait) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Abort when nothing moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				stalled_cycles <= 0;
			else if (stalled_cycles >= STALL_LIMIT) begin
				$display("%0t: no item moved for %0d cycles, %0d results outstanding",
					$time, stalled_cycles, outstanding);
				$display("testbench: FAIL");
				$finish;
			end else
				stalled_cycles <= stalled_cycles + 1;
		end
	end

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = CMD_ENQ_HIGH;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty dequeue, unused code, fill both queues to full,
		// no reclaim on partial drain, priority, drain to empty
		send_item(CMD_DEQ,      32'h12345678);
		send_item(CMD_NOP,      32'hFFFFFFFF);
		send_item(CMD_ENQ_HIGH, 32'h7FFFFFFF);
		send_item(CMD_ENQ_HIGH, 32'h80000000);
		send_item(CMD_ENQ_HIGH, 32'hFFFFFFFF);
		send_item(CMD_ENQ_HIGH, 32'h00000000);
		send_item(CMD_ENQ_HIGH, 32'h5A5A5A5A);
		send_item(CMD_ENQ_LOW,  32'h00000001);
		send_item(CMD_ENQ_LOW,  32'hAAAAAAAA);
		send_item(CMD_ENQ_LOW,  32'h55555555);
		send_item(CMD_ENQ_LOW,  32'hFFFFFFFF);
		send_item(CMD_ENQ_LOW,  32'h0F0F0F0F);
		send_item(CMD_DEQ,      32'h00000000);
		send_item(CMD_DEQ,      32'hFFFFFFFF);
		send_item(CMD_ENQ_HIGH, 32'h13579BDF);
		send_item(CMD_DEQ,      32'h00000000);
		send_item(CMD_DEQ,      32'h00000000);
		send_item(CMD_DEQ,      32'h00000000);
		send_item(CMD_ENQ_HIGH, 32'h2468ACE0);
		send_item(CMD_DEQ,      32'h00000000);
		send_item(CMD_DEQ,      32'h00000000);
		send_item(CMD_DEQ,      32'h00000000);
		send_item(CMD_DEQ,      32'h00000000);
		send_item(CMD_DEQ,      32'h00000000);

		// Random: segments with different command mixes and idling patterns
		sent = 0;
		seg = 0;
		while (sent < RANDOM_ITEMS) begin
			if (seg % 8 == 4)
				wait_for_results();
			seg_len = $urandom_range(8, 40);
			case ($urandom_range(0, 3))
				0: begin cut_high = 35; cut_low = 70; end   // fill-heavy
				1: begin cut_high = 15; cut_low = 30; end   // drain-heavy
				2: begin cut_high = 25; cut_low = 50; end   // balanced
				default: begin cut_high = 10; cut_low = 50; end // mostly low queue
			endcase
			burst = ($urandom_range(0, 3) == 0);
			// Long receiver hold-off while items keep coming back to back
			if (seg == 6) begin
				hold_requests <= hold_requests + 1;
				burst = 1'b1;
				seg_len = 40;
			end
			tx_no_idle = burst;
			rx_no_idle <= burst;
			for (int i = 0; i < seg_len && sent < RANDOM_ITEMS; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < cut_high)
					cmd = CMD_ENQ_HIGH;
				else if (pick < cut_low)
					cmd = CMD_ENQ_LOW;
				else if (pick < 97)
					cmd = CMD_DEQ;
				else
					cmd = CMD_NOP;
				case ($urandom_range(0, 9))
					0: value = 32'h00000000;
					1: value = 32'hFFFFFFFF;
					2: value = 32'h7FFFFFFF;
					3: value = 32'h80000000;
					default: value = $urandom;
				endcase
				send_item(cmd, value);
				sent++;
			end
			seg++;
		end

		// Let everything drain, then keep idling to catch stray results
		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d items: high %0d, low %0d, full %0d, empty %0d, unused %0d",
			sent + 24, high_serves, low_serves, full_rejects, empty_rejects, unused_codes);
		$display("with back-to-back stretches, a long output hold-off and drain pauses");
		if (mismatches == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/tlpq_pkg.sv
rtl/core/tlpq_ram.sv
rtl/core/tlpq_ctrl.sv
rtl/core/tlpq_datapath.sv
rtl/core/two_level_priority_queue_unit.sv
tb/sv/tlpq_checker.sv
tb/sv/testbench.sv
